// ===== rtl/opm_pkg.sv =====
// ---------------------------------------------------------------------------
// opm_pkg: shared types and constants for the oriented point mapper
// Register indexes, mapping modes, operand widths and divider geometry.
// ---------------------------------------------------------------------------
`default_nettype none

package opm_pkg;

    // coordinate width of the input words
    localparam int COORD_BITS_DEF = 16;

    // geometry register widths
    localparam int SIZE_W = 15;
    localparam int OFS_W  = 16;
    localparam int OUT_W  = 32;

    // signed operand ahead of the multiplier (a 32-bit point minus a 16-bit offset)
    localparam int OPA_W = 33;
    // product magnitude, operand times a size
    localparam int MAG_W = OPA_W + SIZE_W;

    // divider: quotient bits resolved per pipeline stage
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = MAG_W / STEP_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_PRESENT  = 3'd0,
        REG_CONTENT_LEFT   = 3'd1,
        REG_CONTENT_TOP    = 3'd2,
        REG_CONTENT_WIDTH  = 3'd3,
        REG_CONTENT_HEIGHT = 3'd4,
        REG_FRAME_WIDTH    = 3'd5,
        REG_FRAME_HEIGHT   = 3'd6,
        REG_ORIENTATION    = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_TO_FRAME  = 2'd0,
        MODE_TO_SCREEN = 2'd1,
        MODE_RADIUS    = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ORI_0    = 3'd0,
        ORI_90   = 3'd1,
        ORI_180  = 3'd2,
        ORI_270  = 3'd3,
        ORI_M0   = 3'd4,
        ORI_M90  = 3'd5,
        ORI_M180 = 3'd6,
        ORI_M270 = 3'd7
    } orient_t;

    // per-item control carried alongside the divider
    typedef struct packed {
        logic  valid;
        logic  ok;
        mode_t mode;
        logic  neg_x;
        logic  neg_y;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/opm_div_pipe.sv =====
// ---------------------------------------------------------------------------
// opm_div_pipe: pipelined unsigned restoring divider
// Magnitude over a nonzero size, STEP_BITS quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module opm_div_pipe (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [opm_pkg::MAG_W-1:0]   num,
    input  wire logic [opm_pkg::SIZE_W-1:0]  den,
    output logic      [opm_pkg::OUT_W-1:0]   quo
);

    localparam int MW = opm_pkg::MAG_W;
    localparam int DW = opm_pkg::SIZE_W;
    localparam int NS = opm_pkg::DIV_STAGES;

    // partial remainder, numerator with quotient shifted in, divisor
    logic [DW-1:0] rem_reg [NS];
    logic [MW-1:0] numq_reg[NS];
    logic [DW-1:0] den_reg [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [DW-1:0] r_in;
        logic [MW-1:0] n_in;
        logic [DW-1:0] d_in;
        logic [DW-1:0] r_next;
        logic [MW-1:0] n_next;

        if (g == 0) begin : g_first
            assign r_in = '0;
            assign n_in = num;
            assign d_in = den;
        end else begin : g_rest
            assign r_in = rem_reg[g-1];
            assign n_in = numq_reg[g-1];
            assign d_in = den_reg[g-1];
        end

        // shift-subtract steps of this stage
        always_comb begin : step
            logic [DW-1:0] r;
            logic [MW-1:0] n;
            logic [DW:0]   t;
            r = r_in;
            n = n_in;
            t = '0;
            for (int j = 0; j < opm_pkg::STEP_BITS; j++) begin
                t = {r, n[MW-1]};
                n = {n[MW-2:0], 1'b0};
                if (t >= {1'b0, d_in}) begin
                    t    = t - {1'b0, d_in};
                    n[0] = 1'b1;
                end
                r = t[DW-1:0];
            end
            r_next = r;
            n_next = n;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= r_next;
                numq_reg[g] <= n_next;
                den_reg[g]  <= d_in;
            end
        end
    end

    assign quo = numq_reg[NS-1][opm_pkg::OUT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/oriented_point_mapper.sv =====
// ---------------------------------------------------------------------------
// oriented_point_mapper: screen/frame coordinate mapping with orientation
// Offset, scale by size ratio and orientation remap, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  ports                                   direction
//  input    s_valid s_ready s_mode s_point_x/y      in
//           s_radius_in
//  result   m_valid m_ready m_valid_res m_out_x/y   out
//           m_out_radius
//  config   cfg_valid cfg_ready cfg_index cfg_data  in
//
//  One word enters per cycle while the pipeline advances; the two 48-bit
//  restoring dividers resolve 4 quotient bits per stage.
//  The whole pipeline advances when the output register is empty or taken,
//  so a stall holds every stage in place. Reset clears the valid bits and the
//  geometry registers; configuration writes are always accepted.
`default_nettype none

module oriented_point_mapper #(
    parameter int COORD_BITS = opm_pkg::COORD_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input words
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_mode,
    input  wire logic signed [COORD_BITS-1:0]     s_point_x,
    input  wire logic signed [COORD_BITS-1:0]     s_point_y,
    input  wire logic signed [COORD_BITS-1:0]     s_radius_in,
    // result words
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_valid_res,
    output logic signed [opm_pkg::OUT_W-1:0]      m_out_x,
    output logic signed [opm_pkg::OUT_W-1:0]      m_out_y,
    output logic signed [opm_pkg::OUT_W-1:0]      m_out_radius,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [opm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [opm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW = opm_pkg::SIZE_W;
    localparam int OW = opm_pkg::OUT_W;
    localparam int AW = opm_pkg::OPA_W;
    localparam int MW = opm_pkg::MAG_W;
    localparam int NS = opm_pkg::DIV_STAGES;

    // geometry registers
    logic                 present_reg;
    logic signed [15:0]   left_reg, top_reg;
    logic [SW-1:0]        cw_reg, ch_reg, fw_reg, fh_reg;
    opm_pkg::orient_t     orient_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            left_reg    <= '0;
            top_reg     <= '0;
            cw_reg      <= '0;
            ch_reg      <= '0;
            fw_reg      <= '0;
            fh_reg      <= '0;
            orient_reg  <= opm_pkg::ORI_0;
        end else if (cfg_valid) begin
            case (opm_pkg::cfg_reg_t'(cfg_index))
                opm_pkg::REG_FRAME_PRESENT:  present_reg <= cfg_data[0];
                opm_pkg::REG_CONTENT_LEFT:   left_reg    <= cfg_data;
                opm_pkg::REG_CONTENT_TOP:    top_reg     <= cfg_data;
                opm_pkg::REG_CONTENT_WIDTH:  cw_reg      <= cfg_data[SW-1:0];
                opm_pkg::REG_CONTENT_HEIGHT: ch_reg      <= cfg_data[SW-1:0];
                opm_pkg::REG_FRAME_WIDTH:    fw_reg      <= cfg_data[SW-1:0];
                opm_pkg::REG_FRAME_HEIGHT:   fh_reg      <= cfg_data[SW-1:0];
                opm_pkg::REG_ORIENTATION:    orient_reg  <= opm_pkg::orient_t'(cfg_data[2:0]);
                default: ;
            endcase
        end
    end

    // pipeline advance: output empty or being taken
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // sizes and offsets at 32 bits
    logic signed [OW-1:0] fw32, fh32, cl32, ct32;
    assign fw32 = {{(OW-SW){1'b0}}, fw_reg};
    assign fh32 = {{(OW-SW){1'b0}}, fh_reg};
    assign cl32 = {{(OW-16){left_reg[15]}}, left_reg};
    assign ct32 = {{(OW-16){top_reg[15]}}, top_reg};

    // ---------------- stage 1: operand selection ----------------
    logic signed [OW-1:0] px32, py32, pr32;
    assign px32 = OW'(s_point_x);
    assign py32 = OW'(s_point_y);
    assign pr32 = OW'(s_radius_in);

    logic                 pt_ok;
    logic                 ok_next;
    logic signed [AW-1:0] ax_next, ay_next;
    logic [SW-1:0]        mx_next, my_next, dx_next, dy_next;
    logic signed [OW-1:0] rx, ry;

    assign pt_ok = present_reg && (cw_reg != '0) && (ch_reg != '0)
                   && (fw_reg != '0) && (fh_reg != '0);

    // frame-to-screen orientation remap, wrapped to 32 bits
    always_comb begin
        case (orient_reg)
            opm_pkg::ORI_0:    begin rx = px32;        ry = py32;        end
            opm_pkg::ORI_90:   begin rx = fw32 - py32; ry = px32;        end
            opm_pkg::ORI_180:  begin rx = fw32 - px32; ry = fh32 - py32; end
            opm_pkg::ORI_270:  begin rx = py32;        ry = fh32 - px32; end
            opm_pkg::ORI_M0:   begin rx = fw32 - px32; ry = py32;        end
            opm_pkg::ORI_M90:  begin rx = fw32 - py32; ry = fh32 - px32; end
            opm_pkg::ORI_M180: begin rx = px32;        ry = fh32 - py32; end
            default:           begin rx = py32;        ry = px32;        end
        endcase
    end

    always_comb begin
        ok_next = 1'b0;
        ax_next = '0;
        ay_next = '0;
        mx_next = cw_reg;
        my_next = ch_reg;
        dx_next = fw_reg;
        dy_next = fh_reg;
        case (opm_pkg::mode_t'(s_mode))
            opm_pkg::MODE_TO_FRAME: begin
                ok_next = pt_ok;
                ax_next = AW'(px32) - AW'(cl32);
                ay_next = AW'(py32) - AW'(ct32);
                mx_next = fw_reg;
                my_next = fh_reg;
                dx_next = cw_reg;
                dy_next = ch_reg;
            end
            opm_pkg::MODE_TO_SCREEN: begin
                ok_next = pt_ok;
                ax_next = AW'(rx);
                ay_next = AW'(ry);
            end
            opm_pkg::MODE_RADIUS: begin
                ok_next = present_reg && (fw_reg != '0) && (cw_reg != '0);
                ax_next = AW'(pr32);
            end
            default: ;
        endcase
    end

    logic                 v1_reg, ok1_reg;
    opm_pkg::mode_t       mode1_reg;
    logic signed [AW-1:0] ax1_reg, ay1_reg;
    logic [SW-1:0]        mx1_reg, my1_reg, dx1_reg, dy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok1_reg   <= ok_next;
            mode1_reg <= opm_pkg::mode_t'(s_mode);
            ax1_reg   <= ax_next;
            ay1_reg   <= ay_next;
            mx1_reg   <= mx_next;
            my1_reg   <= my_next;
            dx1_reg   <= dx_next;
            dy1_reg   <= dy_next;
        end
    end

    // ---------------- stage 2: sign and magnitude ----------------
    logic                 v2_reg, ok2_reg, nx2_reg, ny2_reg;
    opm_pkg::mode_t       mode2_reg;
    logic [AW-1:0]        magx2_reg, magy2_reg;
    logic [SW-1:0]        mx2_reg, my2_reg, dx2_reg, dy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok2_reg   <= ok1_reg;
            mode2_reg <= mode1_reg;
            nx2_reg   <= ax1_reg[AW-1];
            ny2_reg   <= ay1_reg[AW-1];
            magx2_reg <= ax1_reg[AW-1] ? AW'(-ax1_reg) : AW'(ax1_reg);
            magy2_reg <= ay1_reg[AW-1] ? AW'(-ay1_reg) : AW'(ay1_reg);
            mx2_reg   <= mx1_reg;
            my2_reg   <= my1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
        end
    end

    // ---------------- stage 3: scale multiply ----------------
    opm_pkg::side_t side3_reg;
    logic [MW-1:0]  prx3_reg, pry3_reg;
    logic [SW-1:0]  dx3_reg, dy3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg.valid <= 1'b0;
        end else if (en) begin
            side3_reg.valid <= v2_reg;
            side3_reg.ok    <= ok2_reg;
            side3_reg.mode  <= mode2_reg;
            side3_reg.neg_x <= nx2_reg;
            side3_reg.neg_y <= ny2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prx3_reg        <= MW'(magx2_reg) * MW'(mx2_reg);
            pry3_reg        <= MW'(magy2_reg) * MW'(my2_reg);
            dx3_reg         <= dx2_reg;
            dy3_reg         <= dy2_reg;
        end
    end

    // ---------------- divider stages ----------------
    logic [OW-1:0] qx_mag, qy_mag;

    opm_div_pipe u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (prx3_reg),
        .den  (dx3_reg),
        .quo  (qx_mag)
    );

    opm_div_pipe u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (pry3_reg),
        .den  (dy3_reg),
        .quo  (qy_mag)
    );

    // control delay line matching the divider
    opm_pkg::side_t side_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= side3_reg;
            for (int i = 1; i < NS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- stage 4: restore sign ----------------
    opm_pkg::side_t       side4_reg;
    logic signed [OW-1:0] qx4_reg, qy4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side4_reg.valid <= 1'b0;
        end else if (en) begin
            side4_reg <= side_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx4_reg <= side_reg[NS-1].neg_x ? OW'(-qx_mag) : OW'(qx_mag);
            qy4_reg <= side_reg[NS-1].neg_y ? OW'(-qy_mag) : OW'(qy_mag);
        end
    end

    // ---------------- stage 5: remap or offset, output word ----------------
    logic signed [OW-1:0] fx, fy;
    logic signed [OW-1:0] ox_next, oy_next, orad_next;
    logic                 vres_next;

    // screen-to-frame orientation remap
    always_comb begin
        case (orient_reg)
            opm_pkg::ORI_0:    begin fx = qx4_reg;        fy = qy4_reg;        end
            opm_pkg::ORI_90:   begin fx = qy4_reg;        fy = fw32 - qx4_reg; end
            opm_pkg::ORI_180:  begin fx = fw32 - qx4_reg; fy = fh32 - qy4_reg; end
            opm_pkg::ORI_270:  begin fx = fh32 - qy4_reg; fy = qx4_reg;        end
            opm_pkg::ORI_M0:   begin fx = fw32 - qx4_reg; fy = qy4_reg;        end
            opm_pkg::ORI_M90:  begin fx = fh32 - qy4_reg; fy = fw32 - qx4_reg; end
            opm_pkg::ORI_M180: begin fx = qx4_reg;        fy = fh32 - qy4_reg; end
            default:           begin fx = qy4_reg;        fy = qx4_reg;        end
        endcase
    end

    always_comb begin
        vres_next = 1'b0;
        ox_next   = '0;
        oy_next   = '0;
        orad_next = '0;
        if (side4_reg.ok) begin
            case (side4_reg.mode)
                opm_pkg::MODE_TO_FRAME: begin
                    vres_next = 1'b1;
                    ox_next   = fx;
                    oy_next   = fy;
                end
                opm_pkg::MODE_TO_SCREEN: begin
                    vres_next = 1'b1;
                    ox_next   = cl32 + qx4_reg;
                    oy_next   = ct32 + qy4_reg;
                end
                opm_pkg::MODE_RADIUS: begin
                    vres_next = 1'b1;
                    orad_next = qx4_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= side4_reg.valid;
        end
    end

    logic                 vres_reg;
    logic signed [OW-1:0] ox_reg, oy_reg, orad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            vres_reg <= vres_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            orad_reg <= orad_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = vres_reg;
    assign m_out_x      = ox_reg;
    assign m_out_y      = oy_reg;
    assign m_out_radius = orad_reg;

endmodule

`default_nettype wire

// ===== bench/oriented_point_mapper_test.sv =====
// ---------------------------------------------------------------------------
// oriented_point_mapper_test: self-checking bench for the point mapper
// Drives screen/frame point and radius words under varied geometry, predicts
// each result in-bench and compares every result word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module oriented_point_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 16;
    localparam int LIMIT     = 400000;
    localparam int SETTLE    = 30;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] rad;
    } mapped_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic [1:0] s_mode = '0;
    logic signed [CW-1:0] s_point_x = '0, s_point_y = '0, s_radius_in = '0;
    logic m_valid, m_ready = 1'b0, m_valid_res;
    logic signed [31:0] m_out_x, m_out_y, m_out_radius;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [opm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [opm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // geometry mirror
    logic               geo_present;
    logic signed [15:0] geo_left, geo_top;
    logic [14:0]        geo_cw, geo_ch, geo_fw, geo_fh;
    opm_pkg::orient_t   geo_orient;

    mapped_t pending_maps[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle = 0, recv_idle = 0;

    oriented_point_mapper dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // expected mapping for one word under the current geometry
    function automatic mapped_t map_point(logic [1:0] md, logic signed [CW-1:0] xi,
                                          logic signed [CW-1:0] yi,
                                          logic signed [CW-1:0] ri);
        mapped_t r;
        longint px, py, rd, cl, ct, cw, ch, fw, fh, x, y, ax, ay, ox, oy;
        bit pt_ok;
        px = xi; py = yi; rd = ri; cl = geo_left; ct = geo_top;
        cw = geo_cw; ch = geo_ch; fw = geo_fw; fh = geo_fh;
        pt_ok = geo_present && cw != 0 && ch != 0 && fw != 0 && fh != 0;
        r = '0;
        if (md == opm_pkg::MODE_TO_FRAME && pt_ok) begin
            x = longint'(int'((px - cl) * fw / cw));
            y = longint'(int'((py - ct) * fh / ch));
            case (geo_orient)
                opm_pkg::ORI_0:    begin ox = x;      oy = y;      end
                opm_pkg::ORI_90:   begin ox = y;      oy = fw - x; end
                opm_pkg::ORI_180:  begin ox = fw - x; oy = fh - y; end
                opm_pkg::ORI_270:  begin ox = fh - y; oy = x;      end
                opm_pkg::ORI_M0:   begin ox = fw - x; oy = y;      end
                opm_pkg::ORI_M90:  begin ox = fh - y; oy = fw - x; end
                opm_pkg::ORI_M180: begin ox = x;      oy = fh - y; end
                default:           begin ox = y;      oy = x;      end
            endcase
            r.ok = 1'b1; r.x = ox[31:0]; r.y = oy[31:0];
        end else if (md == opm_pkg::MODE_TO_SCREEN && pt_ok) begin
            case (geo_orient)
                opm_pkg::ORI_0:    begin ax = px;      ay = py;      end
                opm_pkg::ORI_90:   begin ax = fw - py; ay = px;      end
                opm_pkg::ORI_180:  begin ax = fw - px; ay = fh - py; end
                opm_pkg::ORI_270:  begin ax = py;      ay = fh - px; end
                opm_pkg::ORI_M0:   begin ax = fw - px; ay = py;      end
                opm_pkg::ORI_M90:  begin ax = fw - py; ay = fh - px; end
                opm_pkg::ORI_M180: begin ax = px;      ay = fh - py; end
                default:           begin ax = py;      ay = px;      end
            endcase
            ax = longint'(int'(ax));
            ay = longint'(int'(ay));
            ox = cl + ax * cw / fw;
            oy = ct + ay * ch / fh;
            r.ok = 1'b1; r.x = ox[31:0]; r.y = oy[31:0];
        end else if (md == opm_pkg::MODE_RADIUS && geo_present && fw != 0 && cw != 0) begin
            ox = rd * cw / fw;
            r.ok = 1'b1; r.rad = ox[31:0];
        end
        return r;
    endfunction

    // register write, only called while idle
    task automatic write_reg(opm_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            opm_pkg::REG_FRAME_PRESENT:  geo_present = val[0];
            opm_pkg::REG_CONTENT_LEFT:   geo_left    = val;
            opm_pkg::REG_CONTENT_TOP:    geo_top     = val;
            opm_pkg::REG_CONTENT_WIDTH:  geo_cw      = val[14:0];
            opm_pkg::REG_CONTENT_HEIGHT: geo_ch      = val[14:0];
            opm_pkg::REG_FRAME_WIDTH:    geo_fw      = val[14:0];
            opm_pkg::REG_FRAME_HEIGHT:   geo_fh      = val[14:0];
            default:                     geo_orient  = opm_pkg::orient_t'(val[2:0]);
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(logic p, logic [15:0] l, logic [15:0] t, logic [14:0] cw,
                                logic [14:0] ch, logic [14:0] fw, logic [14:0] fh,
                                logic [2:0] o);
        write_reg(opm_pkg::REG_FRAME_PRESENT, {15'd0, p});
        write_reg(opm_pkg::REG_CONTENT_LEFT, l);
        write_reg(opm_pkg::REG_CONTENT_TOP, t);
        write_reg(opm_pkg::REG_CONTENT_WIDTH, {1'b0, cw});
        write_reg(opm_pkg::REG_CONTENT_HEIGHT, {1'b0, ch});
        write_reg(opm_pkg::REG_FRAME_WIDTH, {1'b0, fw});
        write_reg(opm_pkg::REG_FRAME_HEIGHT, {1'b0, fh});
        write_reg(opm_pkg::REG_ORIENTATION, {13'd0, o});
    endtask

    // one input word; entered and left at a falling edge, valid left high
    task automatic send_word(logic [1:0] md, logic [15:0] x, logic [15:0] y,
                             logic [15:0] r);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_mode = md; s_point_x = x; s_point_y = y; s_radius_in = r;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_maps.push_back(map_point(md, x, y, r));
        @(negedge aclk);
    endtask

    // wait for all results, then let the pipeline settle
    task automatic drain;
        s_valid = 1'b0;
        while (pending_maps.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_size();
        case ($urandom_range(9))
            0: return 15'd0;
            1: return 15'h7fff;
            2: return 15'd1;
            3: return 15'($urandom_range(1, 4096));
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic test_extremes;
        set_geometry(1'b1, 16'd100, 16'hffce, 15'd1920, 15'd1080, 15'd1280, 15'd720,
                     opm_pkg::ORI_0);
        send_word(opm_pkg::MODE_TO_FRAME, 16'h8000, 16'h8000, 16'h0000);
        send_word(opm_pkg::MODE_TO_FRAME, 16'h7fff, 16'h7fff, 16'hffff);
        send_word(opm_pkg::MODE_TO_SCREEN, 16'h8000, 16'h7fff, 16'h0000);
        send_word(opm_pkg::MODE_TO_SCREEN, 16'h7fff, 16'h8000, 16'h0000);
        send_word(opm_pkg::MODE_RADIUS, 16'h0000, 16'h0000, 16'h8000);
        send_word(opm_pkg::MODE_RADIUS, 16'hffff, 16'hffff, 16'h7fff);
        send_word(opm_pkg::MODE_NONE, 16'h1234, 16'h5678, 16'h1111);
        drain();
        // extreme sizes and offsets
        set_geometry(1'b1, 16'h8000, 16'h7fff, 15'h7fff, 15'd1, 15'd1, 15'h7fff,
                     opm_pkg::ORI_M90);
        send_word(opm_pkg::MODE_TO_FRAME, 16'h7fff, 16'h8000, 16'h0000);
        send_word(opm_pkg::MODE_TO_SCREEN, 16'h8000, 16'h8000, 16'h0000);
        send_word(opm_pkg::MODE_RADIUS, 16'h0000, 16'h0000, 16'h7fff);
        drain();
    endtask

    task automatic test_unusable_geometry;
        // no frame: every mode invalid
        set_geometry(1'b0, 16'd0, 16'd0, 15'd100, 15'd100, 15'd50, 15'd50, opm_pkg::ORI_0);
        send_word(opm_pkg::MODE_TO_FRAME, 16'd10, 16'd10, 16'd5);
        send_word(opm_pkg::MODE_RADIUS, 16'd10, 16'd10, 16'd5);
        drain();
        // zero height: points invalid, radius still valid
        write_reg(opm_pkg::REG_FRAME_PRESENT, 16'd1);
        write_reg(opm_pkg::REG_CONTENT_HEIGHT, 16'd0);
        send_word(opm_pkg::MODE_TO_FRAME, 16'd10, 16'd10, 16'd5);
        send_word(opm_pkg::MODE_TO_SCREEN, 16'd10, 16'd10, 16'd5);
        send_word(opm_pkg::MODE_RADIUS, 16'd10, 16'd10, 16'hfff0);
        drain();
        // zero frame width: all invalid
        write_reg(opm_pkg::REG_CONTENT_HEIGHT, 16'd100);
        write_reg(opm_pkg::REG_FRAME_WIDTH, 16'd0);
        send_word(opm_pkg::MODE_RADIUS, 16'd1, 16'd1, 16'd7);
        send_word(opm_pkg::MODE_TO_SCREEN, 16'd1, 16'd1, 16'd7);
        drain();
    endtask

    task automatic test_orientations;
        set_geometry(1'b1, 16'd7, 16'd3, 15'd300, 15'd200, 15'd150, 15'd400, opm_pkg::ORI_0);
        for (int o = 0; o < 8; o++) begin
            write_reg(opm_pkg::REG_ORIENTATION, 16'(o));
            send_word(opm_pkg::MODE_TO_FRAME, 16'd250, 16'd120, 16'd0);
            send_word(opm_pkg::MODE_TO_SCREEN, 16'd40, 16'd90, 16'd0);
            drain();
        end
    endtask

    task automatic test_random_traffic(int words, int s_pct, int r_pct);
        send_idle = s_pct;
        recv_idle = r_pct;
        for (int n = 0; n < words; n++) begin
            if (n % 50 == 0) begin
                drain();
                if ($urandom_range(9) == 0)
                    set_geometry(1'($urandom_range(1)), pick_coord(), pick_coord(),
                                 15'h7fff, 15'h7fff, 15'd1, 15'd1, 3'($urandom_range(7)));
                else
                    set_geometry($urandom_range(7) != 0, pick_coord(), pick_coord(),
                                 pick_size(), pick_size(), pick_size(), pick_size(),
                                 3'($urandom_range(7)));
            end
            send_word($urandom_range(15) == 0 ? opm_pkg::MODE_NONE : 2'($urandom_range(2)),
                      pick_coord(), pick_coord(), pick_coord());
        end
        drain();
    endtask

    // receiver stalls
    always @(negedge aclk)
        m_ready = aresetn && ($urandom_range(99) >= recv_idle);

    // result check against the oldest expected mapping
    always @(posedge aclk) begin
        mapped_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_maps.size() == 0) begin
                $display("%0t: unexpected result ok=%b x=%0d y=%0d r=%0d", $time,
                         m_valid_res, m_out_x, m_out_y, m_out_radius);
                errors++;
            end else begin
                want = pending_maps.pop_front();
                if (want.ok !== m_valid_res || want.x !== m_out_x || want.y !== m_out_y ||
                    want.rad !== m_out_radius) begin
                    $display("%0t: expected ok=%b x=%0d y=%0d r=%0d, got ok=%b x=%0d y=%0d r=%0d",
                             $time, want.ok, want.x, want.y, want.rad,
                             m_valid_res, m_out_x, m_out_y, m_out_radius);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        geo_present = 0; geo_left = 0; geo_top = 0; geo_cw = 0; geo_ch = 0;
        geo_fw = 0; geo_fh = 0; geo_orient = opm_pkg::ORI_0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_extremes();
        test_unusable_geometry();
        test_orientations();
        test_random_traffic(400, 37, 51);
        test_random_traffic(400, 51, 37);
        test_random_traffic(400, 0, 0);
        if (errors == 0 && pending_maps.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
